### rtl/ppd_pkg.sv
// shared constants and types of the periodic pair distance block
package ppd_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COORD_FRAC_BITS = 16;

  localparam int BOX_W   = 31;
  localparam int INV_W   = 48;
  localparam int INV_LO_W = INV_W / 2;
  localparam int INV_HI_W = INV_W - INV_LO_W;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PLO_W   = DIFF_W + INV_LO_W;
  localparam int PHI_W   = DIFF_W + INV_HI_W;
  localparam int PROD_W  = DIFF_W + INV_W;
  localparam int SHIFT   = COORD_FRAC_BITS + 32;
  localparam int N_W     = PROD_W - SHIFT;
  localparam int NB_W    = N_W + BOX_W;
  localparam int RES_W   = 31;
  localparam int SQ_W    = 2 * RES_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int DIST_W  = 31;

  localparam int AXIS_STAGES = 5;
  localparam int LATENCY     = AXIS_STAGES + 2 + ROOT_W;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_BOX_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_INV_Z = 3'd5;

  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;
  localparam logic [INV_W-1:0] INV_RESET = 48'h0001_0000_0000;

  typedef struct packed {
    logic [2:0][BOX_W-1:0] box;
    logic [2:0][INV_W-1:0] inv;
  } cfg_t;

endpackage

### rtl/ppd_regs.sv
// configuration register file with apb-style access
module ppd_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppd_pkg::ADDR_W-1:0] paddr,
  input  logic [ppd_pkg::DATA_W-1:0] pwdata,
  output logic [ppd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ppd_pkg::cfg_t              cfg_o
);

  ppd_pkg::cfg_t            cfg_q;
  logic [ppd_pkg::IDX_W-1:0] idx;
  logic                      wr;

  assign idx    = paddr[ppd_pkg::ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        cfg_q.box[k] <= ppd_pkg::BOX_RESET;
        cfg_q.inv[k] <= ppd_pkg::INV_RESET;
      end
    end else if (wr) begin
      case (idx)
        ppd_pkg::REG_BOX_X: cfg_q.box[0] <= pwdata[ppd_pkg::BOX_W-1:0];
        ppd_pkg::REG_BOX_Y: cfg_q.box[1] <= pwdata[ppd_pkg::BOX_W-1:0];
        ppd_pkg::REG_BOX_Z: cfg_q.box[2] <= pwdata[ppd_pkg::BOX_W-1:0];
        ppd_pkg::REG_INV_X: cfg_q.inv[0] <= pwdata[ppd_pkg::INV_W-1:0];
        ppd_pkg::REG_INV_Y: cfg_q.inv[1] <= pwdata[ppd_pkg::INV_W-1:0];
        ppd_pkg::REG_INV_Z: cfg_q.inv[2] <= pwdata[ppd_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ppd_pkg::REG_BOX_X: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::BOX_W){1'b0}}, cfg_q.box[0]};
      ppd_pkg::REG_BOX_Y: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::BOX_W){1'b0}}, cfg_q.box[1]};
      ppd_pkg::REG_BOX_Z: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::BOX_W){1'b0}}, cfg_q.box[2]};
      ppd_pkg::REG_INV_X: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::INV_W){1'b0}}, cfg_q.inv[0]};
      ppd_pkg::REG_INV_Y: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::INV_W){1'b0}}, cfg_q.inv[1]};
      ppd_pkg::REG_INV_Z: prdata = {{(ppd_pkg::DATA_W-ppd_pkg::INV_W){1'b0}}, cfg_q.inv[2]};
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/ppd_axis.sv
// per-axis minimum-image residual pipeline
module ppd_axis (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] a_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] b_i,
  input  logic        [ppd_pkg::BOX_W-1:0]       box_i,
  input  logic        [ppd_pkg::INV_W-1:0]       inv_i,
  output logic                                   valid_o,
  output logic        [ppd_pkg::RES_W-1:0]       res_o,
  output logic                                   sat_o
);

  localparam int DW = ppd_pkg::DIFF_W;
  localparam logic [ppd_pkg::PROD_W-1:0] HALF = ppd_pkg::PROD_W'(1) << (ppd_pkg::SHIFT - 1);

  logic [ppd_pkg::AXIS_STAGES-1:0] v_q;

  logic signed [DW-1:0]           diff;
  logic [DW-1:0]                  mag_d, mag1_q, mag2_q, mag3_q, mag4_q;
  logic [ppd_pkg::PLO_W-1:0]      plo_q;
  logic [ppd_pkg::PHI_W-1:0]      phi_q;
  logic [ppd_pkg::PROD_W-1:0]     prod;
  logic [ppd_pkg::N_W-1:0]        n_q;
  logic [ppd_pkg::NB_W-1:0]       nb_q, rfull, mag_ext;
  logic [ppd_pkg::RES_W-1:0]      res_q;
  logic                           sat_q;

  assign diff  = $signed({a_i[ppd_pkg::COORD_WIDTH-1], a_i})
               - $signed({b_i[ppd_pkg::COORD_WIDTH-1], b_i});
  assign mag_d = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign prod = ppd_pkg::PROD_W'(plo_q)
              + (ppd_pkg::PROD_W'(phi_q) << ppd_pkg::INV_LO_W) + HALF;

  assign mag_ext = ppd_pkg::NB_W'(mag4_q);
  assign rfull   = (nb_q >= mag_ext) ? (nb_q - mag_ext) : (mag_ext - nb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ppd_pkg::AXIS_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q <= mag_d;
    plo_q  <= mag1_q * inv_i[ppd_pkg::INV_LO_W-1:0];
    phi_q  <= mag1_q * inv_i[ppd_pkg::INV_W-1:ppd_pkg::INV_LO_W];
    mag2_q <= mag1_q;
    n_q    <= prod[ppd_pkg::PROD_W-1:ppd_pkg::SHIFT];
    mag3_q <= mag2_q;
    nb_q   <= n_q * box_i;
    mag4_q <= mag3_q;
    res_q  <= rfull[ppd_pkg::RES_W-1:0];
    sat_q  <= |rfull[ppd_pkg::NB_W-1:ppd_pkg::RES_W];
  end

  assign valid_o = v_q[ppd_pkg::AXIS_STAGES-1];
  assign res_o   = res_q;
  assign sat_o   = sat_q;

endmodule

### rtl/ppd_sqrt.sv
// pipelined floor square root, one root bit per stage
module ppd_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ppd_pkg::SQ_W-1:0]     val_i,
  input  logic                         sat_i,
  input  logic                         last_i,
  output logic                         valid_o,
  output logic [ppd_pkg::DIST_W-1:0]   dist_o,
  output logic                         last_o
);

  localparam int RW = ppd_pkg::ROOT_W;
  localparam int SW = ppd_pkg::SQ_W;

  logic [RW:0]               v_q;
  logic [RW:0][SW-1:0]       rem_q;
  logic [RW:0][RW-1:0]       root_q;
  logic [RW:0]               sat_q;
  logic [RW:0]               last_q;

  assign v_q[0]    = valid_i;
  assign rem_q[0]  = val_i;
  assign root_q[0] = '0;
  assign sat_q[0]  = sat_i;
  assign last_q[0] = last_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SW-1:0] trial;
    assign trial = (SW'(root_q[k]) << (B + 1)) | (SW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[k+1]  <= sat_q[k];
      last_q[k+1] <= last_q[k];
      if (rem_q[k] >= trial) begin
        rem_q[k+1]  <= rem_q[k] - trial;
        root_q[k+1] <= root_q[k] | (RW'(1) << B);
      end else begin
        rem_q[k+1]  <= rem_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  assign valid_o = v_q[RW];
  assign dist_o  = sat_q[RW] ? {ppd_pkg::DIST_W{1'b1}} : ppd_pkg::DIST_W'(root_q[RW]);
  assign last_o  = last_q[RW];

endmodule

### rtl/periodic_pair_distance_top.sv
// top level of the periodic pair distance block
// throughput: one request per cycle, busy never rises
// the 31-stage square root pipeline sets most of the latency
// reset: asynchronous active low, clears pipeline valids and loads box 1.0, inverse 1.0
// results are strobed for one cycle, the receiver cannot stall
module periodic_pair_distance_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_x_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_y_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_z_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_x_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_y_i,
  input  logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_z_i,
  input  logic                                   last_pair_i,
  output logic                                   result_valid_o,
  output logic        [ppd_pkg::DIST_W-1:0]      distance_o,
  output logic                                   last_pair_out_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [ppd_pkg::ADDR_W-1:0]      paddr,
  input  logic        [ppd_pkg::DATA_W-1:0]      pwdata,
  output logic        [ppd_pkg::DATA_W-1:0]      prdata,
  output logic                                   pready
);

  ppd_pkg::cfg_t cfg;
  logic          req;
  logic [2:0]    av;
  logic [2:0]    asat;
  logic [2:0][ppd_pkg::RES_W-1:0] ares;
  logic signed [2:0][ppd_pkg::COORD_WIDTH-1:0] pa, pb;

  logic [ppd_pkg::AXIS_STAGES-1:0] last_q;
  logic                            v6_q, v7_q;
  logic [2:0][ppd_pkg::SQ_W-1:0]   sq_q;
  logic                            sat6_q, sat7_q, last6_q, last7_q;
  logic [ppd_pkg::SUM_W-1:0]       sum;
  logic [ppd_pkg::SQ_W-1:0]        sum_q;

  assign busy = 1'b0;
  assign req  = start && !busy;
  assign pa   = {point_a_z_i, point_a_y_i, point_a_x_i};
  assign pb   = {point_b_z_i, point_b_y_i, point_b_x_i};

  ppd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    ppd_axis u_axis (
      .clk_i, .rst_ni,
      .valid_i (req),
      .a_i     (pa[k]),
      .b_i     (pb[k]),
      .box_i   (cfg.box[k]),
      .inv_i   (cfg.inv[k]),
      .valid_o (av[k]),
      .res_o   (ares[k]),
      .sat_o   (asat[k])
    );
  end

  assign sum = ppd_pkg::SUM_W'(sq_q[0]) + ppd_pkg::SUM_W'(sq_q[1])
             + ppd_pkg::SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v6_q <= av[0];
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= {last_q[ppd_pkg::AXIS_STAGES-2:0], last_pair_i};
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= ares[k] * ares[k];
    end
    sat6_q  <= |asat;
    last6_q <= last_q[ppd_pkg::AXIS_STAGES-1];
    sum_q   <= sum[ppd_pkg::SQ_W-1:0];
    sat7_q  <= sat6_q || (|sum[ppd_pkg::SUM_W-1:ppd_pkg::SQ_W]);
    last7_q <= last6_q;
  end

  ppd_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v7_q),
    .val_i   (sum_q),
    .sat_i   (sat7_q),
    .last_i  (last7_q),
    .valid_o (result_valid_o),
    .dist_o  (distance_o),
    .last_o  (last_pair_out_o)
  );

endmodule

### rtl/ppd_checker.sv
// port-level checker for the periodic pair distance block
module ppd_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_x_i,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_y_i,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_a_z_i,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_x_i,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_y_i,
  input logic signed [ppd_pkg::COORD_WIDTH-1:0] point_b_z_i,
  input logic                                   last_pair_i,
  input logic                                   result_valid_o,
  input logic        [ppd_pkg::DIST_W-1:0]      distance_o,
  input logic                                   last_pair_out_o
);

  logic same;
  assign same = (point_a_x_i == point_b_x_i) && (point_a_y_i == point_b_y_i)
             && (point_a_z_i == point_b_z_i);

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(ppd_pkg::LATENCY) result_valid_o)
    else $error("request without result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(rst_ni, ppd_pkg::LATENCY)
      |-> $past(start && !busy, ppd_pkg::LATENCY))
    else $error("result without request");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(ppd_pkg::LATENCY) (last_pair_out_o == $past(last_pair_i,
      ppd_pkg::LATENCY)))
    else $error("last pair flag mismatch");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && same |-> ##(ppd_pkg::LATENCY) (distance_o == '0))
    else $error("coincident points give nonzero distance");

endmodule

bind periodic_pair_distance_top ppd_checker u_ppd_checker (.*);
